// ===== hdl/swee_pkg.sv =====
package swee_pkg;

   localparam int RingDepthDefault = 64;
   localparam int TimeWidth        = 48;
   localparam int ProgWidth        = 17;
   localparam int SecsWidth        = 40;
   localparam int StatusWidth      = 3;

   localparam logic [TimeWidth-1:0] DefaultWindowUs = 48'd10000000;
   localparam logic [TimeWidth:0]   MinSpanUs       = 49'd1000000;
   localparam logic [ProgWidth-1:0] ProgressOne     = 17'd65536;
   localparam logic [SecsWidth-1:0] SecondsMax      = '1;
   localparam logic [20:0]          UsecPerSec      = 21'd1000000;

   // Quotient bits from the divider: 32 integer plus 8 fraction, plus one
   // overflow guard bit above the integer part.
   localparam int QuotWidth = 41;
   localparam int NumWidth  = 64 + 8;
   localparam int DenWidth  = 38;

   typedef enum logic [StatusWidth-1:0] {
      ST_VALID   = 3'd0,
      ST_FEW     = 3'd1,
      ST_SHORT   = 3'd2,
      ST_DONE    = 3'd3,
      ST_STALLED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DROP_RD,
      S_DROP_CHK,
      S_APPEND,
      S_RD_FIRST,
      S_RD_LAST,
      S_EVAL,
      S_MUL,
      S_DIV_GO,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [NumWidth-1:0]  num;
      logic [DenWidth-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [QuotWidth-1:0]  quot;
   } div_rsp_type;

endpackage

// ===== hdl/swee_if.sv =====
interface swee_req_if;
   import swee_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [TimeWidth-1:0] timestamp_us;
   logic [ProgWidth-1:0] progress;
   modport source (output valid, cmd, timestamp_us, progress, input ready);
   modport sink   (input valid, cmd, timestamp_us, progress, output ready);
endinterface

interface swee_rsp_if #(parameter int CountWidth = 7);
   import swee_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [StatusWidth-1:0] status;
   logic [SecsWidth-1:0]   seconds_q8;
   logic                   saturated;
   logic [CountWidth-1:0]  sample_count;
   modport source (output valid, status, seconds_q8, saturated, sample_count,
                   input ready);
   modport sink   (input valid, status, seconds_q8, saturated, sample_count,
                   output ready);
endinterface

// ===== hdl/swee_divider.sv =====
// Restoring divider, one quotient bit per cycle. Only the low QuotWidth
// quotient bits are produced; the caller guarantees num/den fits or uses
// the top bit as an overflow flag (see top level).
module swee_divider
   import swee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CntWidth = $clog2(QuotWidth + 1);

   logic [NumWidth-1:0]  num_ff, num_in;
   logic [DenWidth:0]    rem_ff, rem_in;
   logic [DenWidth-1:0]  den_ff, den_in;
   logic [QuotWidth-1:0] quot_ff, quot_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DenWidth+1:0]  trial;
   logic [DenWidth:0]    shifted;

   // One shift-subtract step
   always_comb begin
      shifted = {rem_ff[DenWidth-1:0], num_ff[NumWidth-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         // preload: skip the high bits that cannot yield quotient bits
         num_in  = div_req.num << (NumWidth - QuotWidth);
         rem_in  = {1'b0, div_req.num[NumWidth-1 -: DenWidth]} >> 0;
         rem_in  = '0;
         rem_in[DenWidth-1:0] = div_req.num[NumWidth-1 -: DenWidth] >>
                                (DenWidth - (NumWidth - QuotWidth));
         den_in  = div_req.den;
         quot_in = '0;
         cnt_in  = CntWidth'(QuotWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumWidth-2:0], 1'b0};
         if (!trial[DenWidth+1]) begin
            rem_in  = trial[DenWidth:0];
            quot_in = {quot_ff[QuotWidth-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[QuotWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== hdl/sliding_window_eta_estimator_top.sv =====
// Sliding-window ETA estimator.
// req channel: cmd (0 record, 1 clear), timestamp_us, progress (Q1.16).
// rsp channel: status, seconds_q8 (Q32.8), saturated, sample_count.
// csr_we/csr_wdata write the window length in microseconds (0 = 10 s).
// Each request item yields exactly one response item. The block takes one
// item at a time: req.ready is high only while idle with no response waiting.
// A clear item goes from acceptance through the evaluate state to the output.
// A record item drops stale samples from the ring head (up to RING_DEPTH-1),
// with a final age check when two or more samples are held, then appends the
// new sample and reads the oldest. When an estimate is formed it adds the
// second half multiply on the shared 17x24 multiplier, then the overflow
// check, and it may go through the divider (one quotient bit per cycle).
// With rsp.ready high, req.ready rises once the response has been taken.
// The ring is two memories with registered reads; no clearing pass after
// reset, unwritten entries are never read.
// Reset empties the ring, restores the default window and idles the block.
// A stalled response holds in the output register until rsp.ready; no new
// item is taken until then.
module sliding_window_eta_estimator_top
   import swee_pkg::*;
#(
   parameter int RING_DEPTH = RingDepthDefault
)(
   input  logic                 clock,
   input  logic                 reset,
   swee_req_if.sink             req,
   swee_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [TimeWidth-1:0] csr_wdata
);

   localparam int IdxWidth  = $clog2(RING_DEPTH);
   localparam int CntWidth  = $clog2(RING_DEPTH + 1);
   localparam int HalfWidth = TimeWidth / 2;

   // ring storage
   logic [TimeWidth-1:0] time_mem [RING_DEPTH];
   logic [ProgWidth-1:0] prog_mem [RING_DEPTH];
   logic [TimeWidth-1:0] rd_time_ff;
   logic [ProgWidth-1:0] rd_prog_ff;
   logic                 mem_we;
   logic [IdxWidth-1:0]  mem_addr;

   state_type state_ff, state_in;

   logic [TimeWidth-1:0] window_ff;
   logic [IdxWidth-1:0]  oldest_ff, oldest_in;
   logic [CntWidth-1:0]  held_ff, held_in;
   logic [TimeWidth-1:0] t_new_ff;
   logic [ProgWidth-1:0] p_new_ff;
   logic                 clear_ff;
   logic [TimeWidth-1:0] t0_ff, t0_in;
   logic [ProgWidth-1:0] p0_ff, p0_in;
   logic [63:0]          num_ff, num_in;
   logic [DenWidth-1:0]  den_ff, den_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [SecsWidth-1:0] secs_ff, secs_in;
   logic                 sat_ff, sat_in;

   logic                 req_acc;
   logic [TimeWidth-1:0] win_eff;
   logic [TimeWidth:0]   age;
   logic [TimeWidth:0]   dt;
   logic [ProgWidth:0]   df;
   logic [ProgWidth-1:0] rem;
   logic [HalfWidth-1:0] dt_half;
   logic [ProgWidth+HalfWidth-1:0] part_prod;
   logic                 sat_early;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // ring slot of a sum below 2*RING_DEPTH
   function automatic logic [IdxWidth-1:0] ring_slot(input logic [IdxWidth:0] sum);
      if (sum >= (IdxWidth+1)'(RING_DEPTH))
         ring_slot = IdxWidth'(sum - (IdxWidth+1)'(RING_DEPTH));
      else
         ring_slot = IdxWidth'(sum);
   endfunction

   assign req_acc = req.valid && req.ready;
   assign win_eff = (window_ff == '0) ? DefaultWindowUs : window_ff;
   // signed 49-bit differences
   assign age = {1'b0, t_new_ff} - {1'b0, rd_time_ff};
   assign dt  = {1'b0, t_new_ff} - {1'b0, t0_ff};
   assign df  = {1'b0, p_new_ff} - {1'b0, p0_ff};
   assign rem = ProgressOne - p_new_ff;

   // shared multiplier: low half of the span in S_EVAL, high half in S_MUL
   assign dt_half   = (state_ff == S_MUL) ? dt[TimeWidth-1:HalfWidth] : dt[HalfWidth-1:0];
   assign part_prod = rem * dt_half;
   // integer seconds at or above 2^32 saturate
   assign sat_early = (DenWidth'(num_ff[63:32]) >= den_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_acc) state_in = req.cmd ? S_EVAL : S_DROP_RD;
         S_DROP_RD:  state_in = (held_ff > CntWidth'(1)) ? S_DROP_CHK : S_APPEND;
         S_DROP_CHK: state_in = (!age[TimeWidth] && age[TimeWidth-1:0] > win_eff)
                                ? S_DROP_RD : S_APPEND;
         S_APPEND:   state_in = S_RD_FIRST;
         S_RD_FIRST: state_in = S_RD_LAST;
         S_RD_LAST:  state_in = S_EVAL;
         S_EVAL:     state_in = (!clear_ff && held_ff >= CntWidth'(2) &&
                                 !dt[TimeWidth] && dt >= MinSpanUs &&
                                 p_new_ff < ProgressOne && !df[ProgWidth] &&
                                 df != '0) ? S_MUL : S_OUT;
         S_MUL:      state_in = S_DIV_GO;
         S_DIV_GO:   state_in = sat_early ? S_OUT : S_DIV;
         S_DIV:      if (div_rsp.done) state_in = S_OUT;
         S_OUT:      if (!rsp_valid_ff || rsp.ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      t0_in        = t0_ff;
      p0_in        = p0_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      secs_in      = secs_ff;
      sat_in       = sat_ff;
      mem_we       = 1'b0;
      mem_addr     = oldest_ff;
      div_req      = '0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && req.cmd) begin
               oldest_in = '0;
               held_in   = '0;
            end
         end
         S_DROP_RD: mem_addr = oldest_ff;
         S_DROP_CHK: begin
            if (!age[TimeWidth] && age[TimeWidth-1:0] > win_eff) begin
               oldest_in = ring_slot({1'b0, oldest_ff} + 1'b1);
               held_in   = held_ff - 1'b1;
            end
         end
         S_APPEND: begin
            mem_we = 1'b1;
            if (held_ff >= CntWidth'(RING_DEPTH)) begin
               oldest_in = ring_slot({1'b0, oldest_ff} + 1'b1);
               mem_addr  = oldest_ff;
               held_in   = held_ff;
            end else begin
               mem_addr = ring_slot({1'b0, oldest_ff} + (IdxWidth+1)'(held_ff));
               held_in  = held_ff + 1'b1;
            end
         end
         S_RD_FIRST: mem_addr = oldest_ff;
         S_RD_LAST: begin
            t0_in = rd_time_ff;
            p0_in = rd_prog_ff;
         end
         S_EVAL: begin
            secs_in = '0;
            sat_in  = 1'b0;
            if (clear_ff || held_ff < CntWidth'(2))       status_in = ST_FEW;
            else if (dt[TimeWidth] || dt < MinSpanUs)     status_in = ST_SHORT;
            else if (p_new_ff >= ProgressOne)             status_in = ST_DONE;
            else if (df[ProgWidth] || df == '0)           status_in = ST_STALLED;
            else                                          status_in = ST_VALID;
            num_in = 64'(part_prod);
            den_in = DenWidth'(df[ProgWidth-1:0]) * DenWidth'(UsecPerSec);
         end
         S_MUL: num_in = num_ff + {part_prod[39:0], 24'd0};
         S_DIV_GO: begin
            if (sat_early) begin
               secs_in = SecondsMax;
               sat_in  = 1'b1;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {num_ff, 8'd0};
               div_req.den   = den_ff;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quot[QuotWidth-1]) begin
                  secs_in = SecondsMax;
                  sat_in  = 1'b1;
               end else begin
                  secs_in = div_rsp.quot[SecsWidth-1:0];
               end
            end
         end
         S_OUT: if (!rsp_valid_ff || rsp.ready) rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // ring memories, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[mem_addr] <= t_new_ff;
         prog_mem[mem_addr] <= p_new_ff;
      end
      rd_time_ff <= time_mem[mem_addr];
      rd_prog_ff <= prog_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= DefaultWindowUs;
         oldest_ff    <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) window_ff <= csr_wdata;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_acc) begin
         t_new_ff <= req.timestamp_us;
         p_new_ff <= req.progress;
         clear_ff <= req.cmd;
      end
      t0_ff     <= t0_in;
      p0_ff     <= p0_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      status_ff <= status_in;
      secs_ff   <= secs_in;
      sat_ff    <= sat_in;
   end

   swee_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req.ready        = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.seconds_q8   = secs_ff;
   assign rsp.saturated    = sat_ff;
   assign rsp.sample_count = 7'(held_ff);

endmodule

// ===== hdl/swee_checker.sv =====
module swee_checker
   import swee_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [StatusWidth-1:0] rsp_status,
   input logic [SecsWidth-1:0]   rsp_seconds_q8,
   input logic                   rsp_saturated
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seconds_q8))
      else $error("response changed while stalled");

   // non-valid statuses carry zero estimate
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_VALID |-> rsp_seconds_q8 == '0 && !rsp_saturated)
      else $error("estimate set on non-valid status");

   // one item in flight: ready drops after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted while busy");

   // saturation implies max value
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_seconds_q8 == SecondsMax)
      else $error("saturated without clamp");

endmodule

bind sliding_window_eta_estimator_top swee_checker u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_seconds_q8 (rsp.seconds_q8),
   .rsp_saturated  (rsp.saturated)
);
